// ----- hdl/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, constants and codes shared by the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int SOFT_DEPTH_DEF      = 64;
	localparam int STAGING_DEPTH_DEF   = 64;
	localparam int SLOTS_PER_LEVEL_DEF = 16;
	localparam int ID_WIDTH_DEF        = 8;

	localparam logic [31:0] HIGH_TRIM   = 32'd200;
	localparam logic [31:0] HIGHER_TRIM = 32'd100;
	localparam logic [23:0] AVG_MAX     = 24'hFFFFFF;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_START = 2'd1,
		ACT_SOFT  = 2'd2,
		ACT_HARD  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_QFULL   = 3'd1,
		ST_RUNNING = 3'd2,
		ST_IDLE    = 3'd3,
		ST_TFULL   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DRAIN_RD,
		S_DRAIN_WR,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  level;
		logic [7:0]  task_id;
		logic [31:0] interval_us;
		logic [31:0] delay_us;
		logic [31:0] now_us;
	} cmd_t;

	typedef struct packed {
		logic        fired;
		logic [7:0]  fired_task;
		logic [15:0] jitter_us;
		logic [23:0] average_jitter_q8;
		logic [2:0]  status;
		logic [6:0]  soft_queue_count;
		logic [2:0]  levels_running;
	} rsp_t;

	// due test shared by soft and hard ticks
	function automatic logic is_due(logic [31:0] now, logic [31:0] last, logic [31:0] ival);
		logic [31:0] el;
		el = now - last;
		return (now > last) && (el > ival);
	endfunction

endpackage

// ----- hdl/periodic_task_dispatcher_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit
// Round-robin periodic task dispatcher with a soft queue, a staging queue
// and three level tables held in synchronous memories.
// ----------------------------------------------------------------------------
// Usage: drive cmd and pulse start while busy is low; the command beat is
// taken on that edge and busy rises. Exactly one result beat follows, shown
// on rsp for one cycle with done high; the receiver cannot stall it, and
// busy falls in the same cycle so the next command may be issued.
// Add, soft tick and hard tick return their result beat after the memory
// read and the execute with write back states, then the result state. A
// start action drains the staging queue one entry per read and write state
// pair, so its result beat comes after the loop over all staged entries;
// that loop over the staging memory sets its length.
// A new command can be taken in the cycle showing the previous result beat.
// Reset clears all counters, cursors, started flags and the jitter average
// at once; memory contents stay undefined and only written entries are
// ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_unit
	import ptd_pkg::*;
#(
	parameter int SOFT_DEPTH      = SOFT_DEPTH_DEF,
	parameter int STAGING_DEPTH   = STAGING_DEPTH_DEF,
	parameter int SLOTS_PER_LEVEL = SLOTS_PER_LEVEL_DEF,
	parameter int ID_WIDTH        = ID_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int SAW = $clog2(SOFT_DEPTH);
	localparam int SCW = $clog2(SOFT_DEPTH + 1);
	localparam int GAW = $clog2(STAGING_DEPTH);
	localparam int GCW = $clog2(STAGING_DEPTH + 1);
	localparam int LSW = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
	localparam int LFW = $clog2(SLOTS_PER_LEVEL + 1);
	localparam int LAW = LSW + 2;
	localparam int LDEPTH = 4 * (1 << LSW);

	// memories
	logic [63:0]         soft_tm [SOFT_DEPTH];
	logic [ID_WIDTH-1:0] soft_id [SOFT_DEPTH];
	logic [33+ID_WIDTH:0] stg_m [STAGING_DEPTH];
	logic [63:0]         lvl_tm [LDEPTH];
	logic [ID_WIDTH-1:0] lvl_id [LDEPTH];

	// control state
	fsm_t state_q, state_d;
	cmd_t cmd_q;
	logic [SAW-1:0] head_q;
	logic [SCW-1:0] scount_q;
	logic [GCW-1:0] gcount_q;
	logic [GCW-1:0] drain_q;
	logic [LFW-1:0] fill_q [3];
	logic [LSW-1:0] cur_q [3];
	logic [2:0] started_q;
	logic [23:0] avg_q;
	logic tfull_q;
	rsp_t rsp_q;

	// read data registers
	logic [63:0] soft_rd_q;
	logic [ID_WIDTH-1:0] soft_idr_q;
	logic [33+ID_WIDTH:0] stg_rd_q;
	logic [63:0] lvl_rd_q;
	logic [ID_WIDTH-1:0] lvl_idr_q;

	logic [1:0] li;
	assign li = cmd_q.level - 2'd1;

	logic [LSW-1:0] cur_eff;
	always_comb begin
		cur_eff = cur_q[li];
		if ({{(32-LSW){1'b0}}, cur_q[li]} >= {{(32-LFW){1'b0}}, fill_q[li]})
			cur_eff = '0;
	end

	// read addresses
	logic [SAW-1:0] soft_ra;
	logic [GAW-1:0] stg_ra;
	logic [LAW-1:0] lvl_ra;
	assign soft_ra = head_q;
	assign stg_ra = drain_q[GAW-1:0];
	assign lvl_ra = {li, cur_eff};

	always_ff @(posedge clk) begin
		soft_rd_q  <= soft_tm[soft_ra];
		soft_idr_q <= soft_id[soft_ra];
		stg_rd_q   <= stg_m[stg_ra];
		lvl_rd_q   <= lvl_tm[lvl_ra];
		lvl_idr_q  <= lvl_id[lvl_ra];
	end

	// execute decode
	logic [SAW-1:0] tail_a;
	logic [SCW+SAW:0] tail_sum;
	assign tail_sum = {{(SCW+1){1'b0}}, head_q} + {{(SAW+1){1'b0}}, scount_q};
	always_comb begin
		if (tail_sum >= (SCW+SAW+1)'(SOFT_DEPTH))
			tail_a = SAW'(tail_sum - (SCW+SAW+1)'(SOFT_DEPTH));
		else
			tail_a = SAW'(tail_sum);
	end
	logic [SAW-1:0] head_nx;
	assign head_nx = ({{(32-SAW){1'b0}}, head_q} == SOFT_DEPTH - 1) ? '0 : head_q + 1'b1;
	// tail after the pop: head_nx + count-1 equals old tail
	logic [31:0] s_last, s_ival, s_el, s_jit32;
	logic s_due;
	assign s_last = soft_rd_q[63:32];
	assign s_ival = soft_rd_q[31:0];
	assign s_due  = is_due(cmd_q.now_us, s_last, s_ival);
	assign s_el   = cmd_q.now_us - s_last;
	assign s_jit32 = s_el - s_ival;
	logic [24:0] avg_sum;
	assign avg_sum = {1'b0, avg_q} - {9'd0, avg_q[23:8]} + {9'd0, s_jit32[15:0]};
	logic h_due;
	assign h_due = is_due(cmd_q.now_us, lvl_rd_q[63:32], lvl_rd_q[31:0]);

	logic [31:0] trim_ival;
	always_comb begin
		trim_ival = cmd_q.interval_us;
		if (cmd_q.level == 2'd1 && cmd_q.interval_us > HIGH_TRIM)
			trim_ival = cmd_q.interval_us - HIGH_TRIM;
		if (cmd_q.level == 2'd2 && cmd_q.interval_us > HIGHER_TRIM)
			trim_ival = cmd_q.interval_us - HIGHER_TRIM;
	end

	// drain entry fields
	logic [1:0] d_lvl, d_l;
	assign d_lvl = stg_rd_q[33+ID_WIDTH:32+ID_WIDTH];
	assign d_l = d_lvl - 2'd1;

	// next state, a new command is taken while idle or showing a result
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_DONE: begin
				if (start) state_d = (cmd.action == ACT_START) ? S_DRAIN_RD : S_READ;
				else state_d = S_IDLE;
			end
			S_READ: state_d = S_EXEC;
			S_EXEC: state_d = S_DONE;
			S_DRAIN_RD: state_d = (drain_q >= gcount_q) ? S_DONE : S_DRAIN_WR;
			S_DRAIN_WR: state_d = S_DRAIN_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) cmd_q <= cmd;
	end

	// main read-modify-write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			scount_q <= '0;
			gcount_q <= '0;
			drain_q <= '0;
			for (int k = 0; k < 3; k++) begin
				fill_q[k] <= '0;
				cur_q[k] <= '0;
			end
			started_q <= '0;
			avg_q <= '0;
			tfull_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					drain_q <= '0;
					tfull_q <= 1'b0;
					rsp_q.fired <= 1'b0;
					rsp_q.fired_task <= '0;
					rsp_q.jitter_us <= '0;
					rsp_q.status <= ST_OK;
				end
				S_EXEC: begin
					case (cmd_q.action)
						ACT_ADD: begin
							if (cmd_q.level == 2'd0) begin
								if ({{(32-SCW){1'b0}}, scount_q} >= SOFT_DEPTH)
									rsp_q.status <= ST_QFULL;
								else
									scount_q <= scount_q + 1'b1;
							end else if (started_q[li]) begin
								rsp_q.status <= ST_RUNNING;
							end else if ({{(32-GCW){1'b0}}, gcount_q} >= STAGING_DEPTH) begin
								rsp_q.status <= ST_QFULL;
							end else begin
								gcount_q <= gcount_q + 1'b1;
							end
						end
						ACT_SOFT: begin
							if (scount_q == '0) begin
								rsp_q.status <= ST_IDLE;
							end else begin
								head_q <= head_nx;
								if (s_due) begin
									avg_q <= avg_sum[24] ? AVG_MAX : avg_sum[23:0];
									rsp_q.fired <= 1'b1;
									rsp_q.fired_task <= 8'(soft_idr_q);
									rsp_q.jitter_us <= s_jit32[15:0];
									if (s_ival == '0) scount_q <= scount_q - 1'b1;
								end
							end
						end
						ACT_HARD: begin
							if (cmd_q.level == 2'd0 || fill_q[li] == '0) begin
								rsp_q.status <= ST_IDLE;
							end else begin
								if (h_due) begin
									rsp_q.fired <= 1'b1;
									rsp_q.fired_task <= 8'(lvl_idr_q);
								end
								if ({{(32-LSW){1'b0}}, cur_eff} + 1 >= {{(32-LFW){1'b0}}, fill_q[li]})
									cur_q[li] <= '0;
								else
									cur_q[li] <= cur_eff + 1'b1;
							end
						end
						default: ;
					endcase
				end
				S_DRAIN_RD: begin
					if (drain_q >= gcount_q) begin
						gcount_q <= '0;
						for (int k = 0; k < 3; k++)
							if (fill_q[k] != '0) started_q[k] <= 1'b1;
						if (tfull_q) rsp_q.status <= ST_TFULL;
					end
				end
				S_DRAIN_WR: begin
					drain_q <= drain_q + 1'b1;
					if (d_l != 2'd3) begin
						if ({{(32-LFW){1'b0}}, fill_q[d_l]} >= SLOTS_PER_LEVEL)
							tfull_q <= 1'b1;
						else
							fill_q[d_l] <= fill_q[d_l] + 1'b1;
					end
				end
				S_DONE: begin
					// result beat is on rsp now, clear for the next command
					drain_q <= '0;
					tfull_q <= 1'b0;
					rsp_q.fired <= 1'b0;
					rsp_q.fired_task <= '0;
					rsp_q.jitter_us <= '0;
					rsp_q.status <= ST_OK;
					rsp_q.average_jitter_q8 <= avg_q;
					rsp_q.soft_queue_count <= 7'(scount_q);
					rsp_q.levels_running <= started_q;
				end
				default: ;
			endcase
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			if (cmd_q.action == ACT_ADD && cmd_q.level == 2'd0
				&& {{(32-SCW){1'b0}}, scount_q} < SOFT_DEPTH) begin
				soft_tm[tail_a] <= {cmd_q.now_us + cmd_q.delay_us, cmd_q.interval_us};
				soft_id[tail_a] <= cmd_q.task_id[ID_WIDTH-1:0];
			end
			if (cmd_q.action == ACT_SOFT && scount_q != '0 && !(s_due && s_ival == '0)) begin
				soft_tm[tail_a] <= {s_due ? cmd_q.now_us : s_last, s_ival};
				soft_id[tail_a] <= soft_idr_q;
			end
			if (cmd_q.action == ACT_ADD && cmd_q.level != 2'd0 && !started_q[li]
				&& {{(32-GCW){1'b0}}, gcount_q} < STAGING_DEPTH)
				stg_m[gcount_q[GAW-1:0]] <= {cmd_q.level, cmd_q.task_id[ID_WIDTH-1:0],
					trim_ival};
			if (cmd_q.action == ACT_HARD && cmd_q.level != 2'd0 && fill_q[li] != '0
				&& h_due)
				lvl_tm[lvl_ra] <= {cmd_q.now_us, lvl_rd_q[31:0]};
		end
		if (state_q == S_DRAIN_WR && d_l != 2'd3
			&& {{(32-LFW){1'b0}}, fill_q[d_l]} < SLOTS_PER_LEVEL) begin
			lvl_tm[{d_l, LSW'(fill_q[d_l])}] <= {32'd0, stg_rd_q[31:0]};
			lvl_id[{d_l, LSW'(fill_q[d_l])}] <= stg_rd_q[31+ID_WIDTH:32];
		end
	end

	assign busy = (state_q != S_IDLE) && !(state_q == S_DONE);
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp = rsp_q;
		rsp.average_jitter_q8 = avg_q;
		rsp.soft_queue_count = 7'(scount_q);
		rsp.levels_running = started_q;
	end

endmodule

// ----- hdl/ptd_checker.sv -----
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the command handshake and result beats.
// ----------------------------------------------------------------------------
module ptd_checker
	import ptd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// an accepted command raises busy
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	// done never while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// done is a single-cycle beat
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	// fired beats carry ok status
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.fired |-> rsp.status == ST_OK) else $error("fired with error");

endmodule

bind periodic_task_dispatcher_unit ptd_checker u_ptd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// ----- verif/periodic_task_dispatcher_unit_test.sv -----
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit_test
// Self-checking bench for the periodic task dispatcher. A short list of
// directed commands runs first: empty queues, one-shot and wrapped times,
// interval trimming and refused adds. Random commands follow that fill the
// soft and staging queues and overflow a level table. A behavioral model of
// the queues and tables predicts every result beat; each beat is checked
// field by field against that prediction or a hand-written expected beat.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_unit_test;
	import ptd_pkg::*;

	localparam int SOFT_N  = 64;
	localparam int STAGE_N = 64;
	localparam int SLOT_N  = 16;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	rsp_t rsp;

	periodic_task_dispatcher_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	// dispatcher model state
	logic [31:0] sq_last [SOFT_N];
	logic [31:0] sq_ival [SOFT_N];
	logic [7:0]  sq_id   [SOFT_N];
	int          sq_head;
	int          sq_count;
	logic [1:0]  sg_level [STAGE_N];
	logic [7:0]  sg_id    [STAGE_N];
	logic [31:0] sg_ival  [STAGE_N];
	int          sg_count;
	logic [31:0] lt_last [3][SLOT_N];
	logic [31:0] lt_ival [3][SLOT_N];
	logic [7:0]  lt_id   [3][SLOT_N];
	int          lt_fill   [3];
	int          lt_cursor [3];
	logic [2:0]  lt_run;
	logic [23:0] avg_q8;

	rsp_t        pending_rsp [$];
	int          errors;
	logic [31:0] clock_us;
	logic        idle_on;

	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#400000;
		$display("periodic_task_dispatcher_unit verification failed");
		$finish;
	end

	function automatic logic due_now(logic [31:0] n, logic [31:0] l, logic [31:0] iv);
		return (n > l) && ((n - l) > iv);
	endfunction

	// compute the result of one accepted command and update model state
	function automatic rsp_t dispatch_model(cmd_t c);
		rsp_t        r;
		int          h;
		int          t;
		int          l;
		int          cur;
		logic [31:0] last;
		logic [31:0] iv;
		logic [7:0]  id;
		logic [31:0] j;
		logic [31:0] a;
		bit          drop;
		r = '0;
		r.status = ST_OK;
		case (action_t'(c.action))
			ACT_ADD: begin
				if (c.level == 2'd0) begin
					if (sq_count >= SOFT_N) begin
						r.status = ST_QFULL;
					end else begin
						t = (sq_head + sq_count) % SOFT_N;
						sq_last[t] = c.now_us + c.delay_us;
						sq_ival[t] = c.interval_us;
						sq_id[t] = c.task_id;
						sq_count++;
					end
				end else if (lt_run[c.level - 1]) begin
					r.status = ST_RUNNING;
				end else if (sg_count >= STAGE_N) begin
					r.status = ST_QFULL;
				end else begin
					iv = c.interval_us;
					if (c.level == 2'd1 && iv > HIGH_TRIM) iv = iv - HIGH_TRIM;
					if (c.level == 2'd2 && iv > HIGHER_TRIM) iv = iv - HIGHER_TRIM;
					sg_level[sg_count] = c.level;
					sg_id[sg_count] = c.task_id;
					sg_ival[sg_count] = iv;
					sg_count++;
				end
			end
			ACT_START: begin
				for (int i = 0; i < sg_count; i++) begin
					l = sg_level[i] - 1;
					if (lt_fill[l] >= SLOT_N) begin
						r.status = ST_TFULL;
					end else begin
						lt_ival[l][lt_fill[l]] = sg_ival[i];
						lt_id[l][lt_fill[l]] = sg_id[i];
						lt_last[l][lt_fill[l]] = '0;
						lt_fill[l]++;
					end
				end
				sg_count = 0;
				for (int i = 0; i < 3; i++)
					if (lt_fill[i] > 0) lt_run[i] = 1'b1;
			end
			ACT_SOFT: begin
				if (sq_count == 0) begin
					r.status = ST_IDLE;
				end else begin
					h = sq_head;
					last = sq_last[h];
					iv = sq_ival[h];
					id = sq_id[h];
					sq_head = (h + 1) % SOFT_N;
					sq_count--;
					drop = 1'b0;
					if (due_now(c.now_us, last, iv)) begin
						j = (c.now_us - last - iv) & 32'hFFFF;
						a = {8'd0, avg_q8} - {16'd0, avg_q8[23:8]} + j;
						avg_q8 = (a > {8'd0, AVG_MAX}) ? AVG_MAX : a[23:0];
						r.fired = 1'b1;
						r.fired_task = id;
						r.jitter_us = j[15:0];
						last = c.now_us;
						drop = (iv == '0);
					end
					if (!drop) begin
						t = (sq_head + sq_count) % SOFT_N;
						sq_last[t] = last;
						sq_ival[t] = iv;
						sq_id[t] = id;
						sq_count++;
					end
				end
			end
			default: begin
				if (c.level == 2'd0 || lt_fill[c.level - 1] == 0) begin
					r.status = ST_IDLE;
				end else begin
					l = c.level - 1;
					cur = (lt_cursor[l] >= lt_fill[l]) ? 0 : lt_cursor[l];
					if (due_now(c.now_us, lt_last[l][cur], lt_ival[l][cur])) begin
						lt_last[l][cur] = c.now_us;
						r.fired = 1'b1;
						r.fired_task = lt_id[l][cur];
					end
					cur++;
					lt_cursor[l] = (cur >= lt_fill[l]) ? 0 : cur;
				end
			end
		endcase
		r.average_jitter_q8 = avg_q8;
		r.soft_queue_count = sq_count[6:0];
		r.levels_running = lt_run;
		return r;
	endfunction

	function automatic cmd_t mk_cmd(action_t a, logic [1:0] lv, logic [7:0] id,
		logic [31:0] iv, logic [31:0] dl, logic [31:0] nw);
		cmd_t c;
		c.action = a;
		c.level = lv;
		c.task_id = id;
		c.interval_us = iv;
		c.delay_us = dl;
		c.now_us = nw;
		return c;
	endfunction

	function automatic void add_row(cmd_t c, bit typed, rsp_t w);
		dir_row_t row;
		row.c = c;
		row.typed = typed;
		row.want = w;
		dir_rows.push_back(row);
	endfunction

	function automatic rsp_t mk_rsp(logic f, logic [7:0] id, logic [15:0] j,
		logic [23:0] av, status_t st, logic [6:0] cnt, logic [2:0] run);
		rsp_t r;
		r.fired = f;
		r.fired_task = id;
		r.jitter_us = j;
		r.average_jitter_q8 = av;
		r.status = st;
		r.soft_queue_count = cnt;
		r.levels_running = run;
		return r;
	endfunction

	// random interval, mostly short so tasks come due
	function automatic logic [31:0] rand_ival();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) return '0;
		if (p < 20) return $urandom;
		if (p < 60) return $urandom_range(0, 400);
		return $urandom_range(0, 2000);
	endfunction

	// random command; mode selects the mix of actions
	function automatic cmd_t rand_cmd(int mode);
		int          p;
		action_t     a;
		logic [1:0]  lv;
		logic [31:0] dl;
		clock_us = clock_us + $urandom_range(0, 300);
		p = $urandom_range(0, 99);
		lv = 2'($urandom_range(0, 3));
		case (mode)
			0: begin
				a = (p < 30) ? ACT_ADD : (p < 60) ? ACT_SOFT : (p < 80) ? ACT_HARD : ACT_ADD;
				if (a == ACT_ADD && p < 30) lv = 2'd0;
			end
			1: begin
				a = ACT_ADD;
				lv = 2'd0;
			end
			2: begin
				a = ACT_ADD;
				lv = (p < 10) ? 2'd1 : (p < 60) ? 2'd2 : 2'd3;
			end
			3: begin
				a = ACT_SOFT;
			end
			default: begin
				a = (p < 25) ? ACT_ADD : (p < 30) ? ACT_START : (p < 65) ? ACT_SOFT : ACT_HARD;
			end
		endcase
		dl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500);
		return mk_cmd(a, lv, 8'($urandom), rand_ival(), dl,
			($urandom_range(0, 19) == 0) ? $urandom : clock_us);
	endfunction

	// present one command beat and hold it until taken
	task automatic send_cmd(cmd_t c, bit typed, rsp_t w);
		rsp_t r;
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = dispatch_model(c);
		pending_rsp.push_back(typed ? w : r);
		if (idle_on && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_random(int n, int mode);
		for (int i = 0; i < n; i++) send_cmd(rand_cmd(mode), 1'b0, '0);
	endtask

	// result beat checker
	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result beat with nothing pending");
				errors++;
			end else begin
				w = pending_rsp.pop_front();
				if (rsp.fired !== w.fired) begin
					$error("fired: expected %0h actual %0h", w.fired, rsp.fired);
					errors++;
				end
				if (rsp.fired_task !== w.fired_task) begin
					$error("fired_task: expected %0h actual %0h", w.fired_task, rsp.fired_task);
					errors++;
				end
				if (rsp.jitter_us !== w.jitter_us) begin
					$error("jitter_us: expected %0h actual %0h", w.jitter_us, rsp.jitter_us);
					errors++;
				end
				if (rsp.average_jitter_q8 !== w.average_jitter_q8) begin
					$error("average_jitter_q8: expected %0h actual %0h",
						w.average_jitter_q8, rsp.average_jitter_q8);
					errors++;
				end
				if (rsp.status !== w.status) begin
					$error("status: expected %0h actual %0h", w.status, rsp.status);
					errors++;
				end
				if (rsp.soft_queue_count !== w.soft_queue_count) begin
					$error("soft_queue_count: expected %0h actual %0h",
						w.soft_queue_count, rsp.soft_queue_count);
					errors++;
				end
				if (rsp.levels_running !== w.levels_running) begin
					$error("levels_running: expected %0h actual %0h",
						w.levels_running, rsp.levels_running);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		errors = 0;
		clock_us = '0;
		idle_on = 1'b1;
		sq_head = 0;
		sq_count = 0;
		sg_count = 0;
		lt_run = '0;
		avg_q8 = '0;
		for (int i = 0; i < 3; i++) begin
			lt_fill[i] = 0;
			lt_cursor[i] = 0;
		end

		// empty queues, one-shot firing, wrapped last-run time, lone level start
		add_row(mk_cmd(ACT_SOFT, 2'd0, 8'h00, '0, '0, '0), 1, mk_rsp(0, 0, 0, 0, ST_IDLE, 0, 0));
		add_row(mk_cmd(ACT_HARD, 2'd0, 8'h00, '0, '0, '0), 1, mk_rsp(0, 0, 0, 0, ST_IDLE, 0, 0));
		add_row(mk_cmd(ACT_HARD, 2'd3, 8'h00, '0, '0, 32'd9), 1, mk_rsp(0, 0, 0, 0, ST_IDLE, 0, 0));
		add_row(mk_cmd(ACT_ADD, 2'd0, 8'hFF, '0, '0, '0), 1, mk_rsp(0, 0, 0, 0, ST_OK, 1, 0));
		add_row(mk_cmd(ACT_SOFT, 2'd0, 8'h00, '0, '0, '0), 1, mk_rsp(0, 0, 0, 0, ST_OK, 1, 0));
		add_row(mk_cmd(ACT_SOFT, 2'd0, 8'h00, '0, '0, 32'd5), 1,
			mk_rsp(1, 8'hFF, 16'd5, 24'd5, ST_OK, 0, 0));
		add_row(mk_cmd(ACT_ADD, 2'd0, 8'h01, 32'hFFFFFFFF, 32'hFFFFFFFF, '0), 1,
			mk_rsp(0, 0, 0, 24'd5, ST_OK, 1, 0));
		add_row(mk_cmd(ACT_SOFT, 2'd0, 8'h00, '0, '0, 32'hFFFFFFFF), 1,
			mk_rsp(0, 0, 0, 24'd5, ST_OK, 1, 0));
		add_row(mk_cmd(ACT_ADD, 2'd0, 8'h5A, 32'd10, 32'd20, 32'd100), 0, '0);
		add_row(mk_cmd(ACT_SOFT, 2'd0, 8'h00, '0, '0, 32'd200), 0, '0);
		add_row(mk_cmd(ACT_SOFT, 2'd0, 8'h00, '0, '0, 32'd400), 0, '0);
		add_row(mk_cmd(ACT_ADD, 2'd1, 8'h80, 32'hFFFFFFFF, '0, '0), 0, '0);
		add_row(mk_cmd(ACT_ADD, 2'd1, 8'h11, 32'd150, '0, '0), 0, '0);
		add_row(mk_cmd(ACT_ADD, 2'd1, 8'h22, 32'd201, '0, '0), 0, '0);
		add_row(mk_cmd(ACT_ADD, 2'd1, 8'h33, 32'd0, '0, '0), 0, '0);
		add_row(mk_cmd(ACT_START, 2'd0, 8'h00, '0, '0, '0), 0, '0);
		add_row(mk_cmd(ACT_ADD, 2'd1, 8'h44, 32'd5, '0, '0), 1,
			mk_rsp(0, 0, 0, 24'd275, ST_RUNNING, 2, 3'b001));
		add_row(mk_cmd(ACT_HARD, 2'd1, 8'h00, '0, '0, '0), 0, '0);
		add_row(mk_cmd(ACT_HARD, 2'd1, 8'h00, '0, '0, 32'd120), 0, '0);
		add_row(mk_cmd(ACT_HARD, 2'd1, 8'h00, '0, '0, 32'd500), 0, '0);
		add_row(mk_cmd(ACT_HARD, 2'd1, 8'h00, '0, '0, 32'd501), 0, '0);
		add_row(mk_cmd(ACT_HARD, 2'd1, 8'h00, '0, '0, 32'hFFFFFFFF), 0, '0);
		add_row(mk_cmd(ACT_HARD, 2'd2, 8'h00, '0, '0, 32'd7), 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

		// mixed traffic, levels two and three still staging
		send_random(90, 0);
		// soft queue overflow, then soft ticks that retire due one-shot tasks
		send_random(70, 1);
		send_random(40, 3);
		// staging overflow, quiet pause, then start with table overflow
		send_random(70, 2);
		start <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
		send_cmd(mk_cmd(ACT_START, 2'd0, 8'h00, '0, '0, clock_us), 0, '0);
		send_cmd(mk_cmd(ACT_START, 2'd0, 8'h00, '0, '0, clock_us), 0, '0);
		// free mix, with a stretch of back-to-back beats
		send_random(60, 4);
		idle_on = 1'b0;
		send_random(80, 4);
		idle_on = 1'b1;
		send_random(60, 4);
		start <= 1'b0;

		n = 0;
		while (pending_rsp.size() != 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("periodic_task_dispatcher_unit verification clean");
		end else begin
			$display("periodic_task_dispatcher_unit verification failed");
		end
		$finish;
	end

endmodule
